// ===== rtl/pairwise_energy_class_scorer_top_macros.svh =====
// Assertion macros used by the scorer's datapath.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef PAIRWISE_ENERGY_CLASS_SCORER_TOP_MACROS_SVH
`define PAIRWISE_ENERGY_CLASS_SCORER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PECS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pecs assertion failed");
`define PECS_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pecs assertion failed");
`define PECS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pecs assertion failed");
`else
`define PECS_ASSERT_NEVER(lbl, expr)
`define PECS_ASSERT_IMPLY(lbl, pre, post)
`define PECS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/pecs_pkg.sv =====
// Package for the pairwise energy class scorer: field widths, command and
// register codes, controller states, command/status structs, saturating add.
// No dependencies.
package pecs_pkg;

  localparam int NUM_CLASSES_DEF = 4;
  localparam int NUM_VARS_DEF    = 16;
  localparam int NUM_LEVELS_DEF  = 4;

  localparam int CMD_W      = 3;
  localparam int CLASS_W    = 2;
  localparam int VAR_W      = 4;
  localparam int LEVEL_W    = 2;
  localparam int WEIGHT_W   = 32;
  localparam int OBS_W      = 3;
  localparam int LC_W       = 3;
  localparam int ACC_W      = 48;
  localparam int SDATA_W    = 56;
  localparam int MDATA_W    = 56;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CMD_W-1:0] CMD_SITE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PAIR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BIAS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEVEL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_CLASSES = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_NAIVE_MODE  = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLASS,
    ST_USE_RD,
    ST_USE_WR,
    ST_I_RD,
    ST_SITE_RD,
    ST_SITE_ACC,
    ST_J_RD,
    ST_PAIR_RD,
    ST_PAIR_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic ready;
    logic clr_step;
    logic qlen_clear;
    logic class_init;
    logic use_store;
    logic vi_clear;
    logic vi_inc;
    logic qread_j;
    logic site_latch;
    logic site_acc;
    logic vj_clear;
    logic vj_inc;
    logic pair_read;
    logic pair_acc;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic ends_query;
    logic n_zero;
    logic vi_done;
    logic vj_done;
    logic usable_i;
    logic naive;
    logic out_free;
    logic cls_last;
  } ctrl_sts_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ACC_W-1:0] term
  );
    logic [ACC_W:0] sum;
    sum = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      return sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/pecs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pecs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pecs_ctrl.sv =====
// Sequencer of the scorer: clearing pass, beat intake, per-class scoring loops.
// Depends on pecs_pkg; drives the datapath through ctrl_cmd_t.
module pecs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  pecs_pkg::ctrl_sts_t   sts,
  output pecs_pkg::ctrl_cmd_t   cmd
);
  import pecs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:     if (sts.in_valid && sts.ends_query && !sts.n_zero) state_next = ST_CLASS;
      ST_CLASS:    state_next = ST_USE_RD;
      ST_USE_RD:   state_next = sts.vi_done ? ST_I_RD : ST_USE_WR;
      ST_USE_WR:   state_next = ST_USE_RD;
      ST_I_RD:     state_next = sts.vi_done ? ST_EMIT : ST_SITE_RD;
      ST_SITE_RD:  state_next = ST_SITE_ACC;
      ST_SITE_ACC: state_next = (!sts.usable_i || sts.naive) ? ST_I_RD : ST_J_RD;
      ST_J_RD:     state_next = sts.vj_done ? ST_I_RD : ST_PAIR_RD;
      ST_PAIR_RD:  state_next = ST_PAIR_ACC;
      ST_PAIR_ACC: state_next = ST_J_RD;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = sts.cls_last ? ST_IDLE : ST_CLASS;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        cmd.ready = 1'b1;
        cmd.qlen_clear = sts.in_valid && sts.ends_query && sts.n_zero;
      end
      ST_CLASS: cmd.class_init = 1'b1;
      ST_USE_RD: cmd.vi_clear = sts.vi_done;
      ST_USE_WR: begin
        cmd.use_store = 1'b1;
        cmd.vi_inc = 1'b1;
      end
      ST_I_RD: cmd = '0;
      ST_SITE_RD: cmd.site_latch = 1'b1;
      ST_SITE_ACC: begin
        cmd.site_acc = 1'b1;
        if (!sts.usable_i || sts.naive) begin
          cmd.vi_inc = 1'b1;
        end else begin
          cmd.vj_clear = 1'b1;
        end
      end
      ST_J_RD: begin
        cmd.vi_inc = sts.vj_done;
        cmd.qread_j = !sts.vj_done;
      end
      ST_PAIR_RD: begin
        cmd.qread_j = 1'b1;
        cmd.pair_read = 1'b1;
      end
      ST_PAIR_ACC: begin
        cmd.pair_acc = 1'b1;
        cmd.vj_inc = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.qlen_clear = sts.out_free && sts.cls_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/pecs_datapath.sv =====
// Datapath of the scorer: weight and level memories, query store, usable mask,
// saturating accumulator, output register. Depends on pecs_pkg, pecs_ram and the macros header.
`include "pairwise_energy_class_scorer_top_macros.svh"
module pecs_datapath #(
  parameter int NUM_CLASSES = pecs_pkg::NUM_CLASSES_DEF,
  parameter int NUM_VARS    = pecs_pkg::NUM_VARS_DEF,
  parameter int NUM_LEVELS  = pecs_pkg::NUM_LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pecs_pkg::ctrl_cmd_t                cmd,
  output pecs_pkg::ctrl_sts_t                sts,
  input  logic                               s_tvalid,
  input  logic [pecs_pkg::CMD_W-1:0]         s_tuser,
  input  logic [pecs_pkg::SDATA_W-1:0]       s_tdata,
  input  logic                               s_tlast,
  input  logic                               cfg_we,
  input  logic [pecs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pecs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [pecs_pkg::MDATA_W-1:0]       m_tdata,
  output logic                               m_tlast
);
  import pecs_pkg::*;

  localparam int SITE_DEPTH = NUM_CLASSES * NUM_VARS * NUM_LEVELS;
  localparam int PAIR_DEPTH = NUM_CLASSES * NUM_VARS * NUM_VARS * NUM_LEVELS * NUM_LEVELS;
  localparam int LC_DEPTH   = NUM_CLASSES * NUM_VARS;
  localparam int SA_W = $clog2(SITE_DEPTH);
  localparam int PA_W = $clog2(PAIR_DEPTH);
  localparam int LA_W = $clog2(LC_DEPTH);
  localparam int VW   = $clog2(NUM_VARS);
  localparam int VCW  = $clog2(NUM_VARS + 1);
  localparam int LW   = $clog2(NUM_LEVELS);
  localparam int CW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int NW   = ($clog2(NUM_CLASSES + 1) > CFG_DATA_W) ?
                        $clog2(NUM_CLASSES + 1) : CFG_DATA_W;
  localparam int PAD_W = MDATA_W - CLASS_W - ACC_W;

  logic [CLASS_W-1:0]  in_class;
  logic [VAR_W-1:0]    in_v1;
  logic [VAR_W-1:0]    in_v2;
  logic [LEVEL_W-1:0]  in_l1;
  logic [LEVEL_W-1:0]  in_l2;
  logic [WEIGHT_W-1:0] in_weight;
  logic [OBS_W-1:0]    in_obs;

  assign in_class  = s_tdata[1:0];
  assign in_v1     = s_tdata[5:2];
  assign in_v2     = s_tdata[9:6];
  assign in_l1     = s_tdata[11:10];
  assign in_l2     = s_tdata[13:12];
  assign in_weight = s_tdata[45:14];
  assign in_obs    = s_tdata[48:46];

  logic take;
  logic wr_ok;
  logic site_wr;
  logic pair_wr;
  logic bias_wr;
  logic lc_wr;
  logic q_wr;

  logic [CFG_DATA_W-1:0] num_classes;
  logic                  naive_mode;
  logic [NW-1:0]         n_eff;
  logic [NW-1:0]         cls;
  logic [CW-1:0]         cls_i;
  logic [VCW-1:0]        qlen;
  logic [VCW-1:0]        vi;
  logic [VCW-1:0]        vj;
  logic [VW-1:0]         vi_i;
  logic [VW-1:0]         vj_i;
  logic [LA_W-1:0]       clr_addr;
  logic [NUM_VARS-1:0]   usable;
  logic [LW-1:0]         li;
  logic [LW-1:0]         cur_level;
  logic                  pair_ok;

  logic signed [WEIGHT_W-1:0] bias [NUM_CLASSES];
  logic signed [ACC_W-1:0]    acc;
  logic [CLASS_W-1:0]         out_class;
  logic signed [ACC_W-1:0]    out_score;
  logic                       out_last;

  logic [SA_W-1:0]     site_waddr;
  logic [SA_W-1:0]     site_raddr;
  logic [WEIGHT_W-1:0] site_rdata;
  logic [PA_W-1:0]     pair_waddr;
  logic [PA_W-1:0]     pair_raddr;
  logic [WEIGHT_W-1:0] pair_rdata;
  logic                lc_we;
  logic [LA_W-1:0]     lc_waddr;
  logic [LC_W-1:0]     lc_wdata;
  logic [LA_W-1:0]     lc_raddr;
  logic [LC_W-1:0]     lc_rdata;
  logic [VW-1:0]       q_raddr;
  logic [OBS_W-1:0]    q_rdata;

  function automatic logic is_usable(input logic [OBS_W-1:0] x, input logic [LC_W-1:0] lc);
    return (x != '0) && (int'(x) <= NUM_LEVELS) && (x <= lc);
  endfunction

  // Table writes and query beats arriving from the input stream.
  assign take    = cmd.ready && s_tvalid;
  assign wr_ok   = take && (s_tuser <= CMD_LEVEL) && (int'(in_class) < NUM_CLASSES) &&
                   (int'(in_v1) < NUM_VARS);
  assign site_wr = wr_ok && (s_tuser == CMD_SITE) && (int'(in_l1) < NUM_LEVELS);
  assign pair_wr = wr_ok && (s_tuser == CMD_PAIR) && (int'(in_v2) < NUM_VARS) &&
                   (int'(in_l1) < NUM_LEVELS) && (int'(in_l2) < NUM_LEVELS);
  assign bias_wr = wr_ok && (s_tuser == CMD_BIAS);
  assign lc_wr   = wr_ok && (s_tuser == CMD_LEVEL);
  assign q_wr    = take && (s_tuser == CMD_QUERY) && (int'(qlen) < NUM_VARS);

  assign site_waddr = SA_W'((int'(in_class) * NUM_VARS + int'(in_v1)) * NUM_LEVELS +
                            int'(in_l1));
  assign pair_waddr = PA_W'((((int'(in_class) * NUM_VARS + int'(in_v1)) * NUM_VARS +
                              int'(in_v2)) * NUM_LEVELS + int'(in_l1)) * NUM_LEVELS +
                            int'(in_l2));

  assign lc_we    = cmd.clr_step || lc_wr;
  assign lc_waddr = cmd.clr_step ? clr_addr :
                    LA_W'(int'(in_class) * NUM_VARS + int'(in_v1));
  assign lc_wdata = cmd.clr_step ? '0 : in_weight[LC_W-1:0];

  // Read addressing for the scoring loops.
  assign cls_i     = cls[CW-1:0];
  assign vi_i      = vi[VW-1:0];
  assign vj_i      = vj[VW-1:0];
  assign q_raddr   = cmd.qread_j ? vj_i : vi_i;
  assign lc_raddr  = LA_W'(int'(cls_i) * NUM_VARS + int'(vi_i));
  assign cur_level = ((q_rdata != '0) && (int'(q_rdata) <= NUM_LEVELS)) ?
                     LW'(int'(q_rdata) - 1) : '0;
  assign site_raddr = SA_W'((int'(cls_i) * NUM_VARS + int'(vi_i)) * NUM_LEVELS +
                            int'(cur_level));
  assign pair_raddr = PA_W'((((int'(cls_i) * NUM_VARS + int'(vi_i)) * NUM_VARS +
                              int'(vj_i)) * NUM_LEVELS + int'(li)) * NUM_LEVELS +
                            int'(cur_level));

  pecs_ram #(.WIDTH(WEIGHT_W), .DEPTH(SITE_DEPTH)) u_site_ram (
    .clk   (clk),
    .we    (site_wr),
    .waddr (site_waddr),
    .wdata (in_weight),
    .raddr (site_raddr),
    .rdata (site_rdata)
  );

  pecs_ram #(.WIDTH(WEIGHT_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_wr),
    .waddr (pair_waddr),
    .wdata (in_weight),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  pecs_ram #(.WIDTH(LC_W), .DEPTH(LC_DEPTH)) u_level_ram (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .raddr (lc_raddr),
    .rdata (lc_rdata)
  );

  pecs_ram #(.WIDTH(OBS_W), .DEPTH(NUM_VARS)) u_query_ram (
    .clk   (clk),
    .we    (q_wr),
    .waddr (qlen[VW-1:0]),
    .wdata (in_obs),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign n_eff = (int'(num_classes) > NUM_CLASSES) ? NW'(NUM_CLASSES) : NW'(num_classes);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= CFG_DATA_W'(1);
      naive_mode  <= 1'b0;
      clr_addr    <= '0;
      qlen        <= '0;
      cls         <= '0;
      vi          <= '0;
      vj          <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we && (cfg_addr == REG_NUM_CLASSES)) begin
        num_classes <= cfg_wdata;
      end
      if (cfg_we && (cfg_addr == REG_NAIVE_MODE)) begin
        naive_mode <= cfg_wdata[0];
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + LA_W'(1);
      end
      if (cmd.qlen_clear) begin
        qlen <= '0;
      end else if (q_wr) begin
        qlen <= qlen + VCW'(1);
      end
      if (cmd.ready) begin
        cls <= '0;
      end else if (cmd.emit) begin
        cls <= cls + NW'(1);
      end
      if (cmd.class_init || cmd.vi_clear) begin
        vi <= '0;
      end else if (cmd.vi_inc) begin
        vi <= vi + VCW'(1);
      end
      if (cmd.vj_clear) begin
        vj <= '0;
      end else if (cmd.vj_inc) begin
        vj <= vj + VCW'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (bias_wr) begin
      bias[CW'(in_class)] <= in_weight;
    end
    if (cmd.use_store) begin
      usable[vi_i] <= is_usable(q_rdata, lc_rdata);
    end
    if (cmd.site_latch) begin
      li <= cur_level;
    end
    if (cmd.pair_read) begin
      pair_ok <= usable[vj_i] && (vj != vi);
    end
    if (cmd.class_init) begin
      acc <= {{(ACC_W - WEIGHT_W){bias[cls_i][WEIGHT_W-1]}}, bias[cls_i]};
    end else if (cmd.site_acc && usable[vi_i]) begin
      acc <= sat_add(acc, {{(ACC_W - WEIGHT_W){site_rdata[WEIGHT_W-1]}}, site_rdata});
    end else if (cmd.pair_acc && pair_ok) begin
      acc <= sat_add(acc, {{(ACC_W - WEIGHT_W + 1){pair_rdata[WEIGHT_W-1]}},
                           pair_rdata[WEIGHT_W-1:1]});
    end
    if (cmd.emit) begin
      out_class <= cls[CLASS_W-1:0];
      out_score <= acc;
      out_last  <= sts.cls_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_score, out_class};
  assign m_tlast = out_last;

  assign sts.clr_last   = (clr_addr == LA_W'(LC_DEPTH - 1));
  assign sts.in_valid   = s_tvalid;
  assign sts.ends_query = (s_tuser == CMD_QUERY) && s_tlast;
  assign sts.n_zero     = (num_classes == '0);
  assign sts.vi_done    = (vi == qlen);
  assign sts.vj_done    = (vj == qlen);
  assign sts.usable_i   = usable[vi_i];
  assign sts.naive      = naive_mode;
  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.cls_last   = ((cls + NW'(1)) == n_eff);

  `PECS_ASSERT_NEVER(a_qlen_bound, qlen > VCW'(NUM_VARS))
  `PECS_ASSERT_IMPLY(a_emit_free, cmd.emit, sts.out_free)
  `PECS_ASSERT_IMPLY(a_pair_range, cmd.pair_read, (vi < qlen) && (vj < qlen))
  `PECS_ASSERT_NEXT(a_query_done, cmd.emit && sts.cls_last, qlen == '0)

endmodule

// ===== rtl/pairwise_energy_class_scorer_top.sv =====
// Top level of the pairwise energy class scorer: stream ports, config port,
// sequencer and datapath. Depends on pecs_pkg, pecs_ctrl and pecs_datapath.
//
// After reset the block clears the level count memory with s_tready low.
// Table writes and query beats that do not end a query are taken in the idle
// state, which the block stays in. A beat with tlast that ends a query starts
// scoring unless num_classes is zero, and s_tready then stays low until the
// last score has been handed to the output register. Per class, the scorer
// marks the usable query variables, adds the site weight of each usable one
// and, unless naive mode is set, runs a pair loop for it over the stored
// query beats, each pair taking a query memory read, a pair weight read
// through the registered read port of the pair memory, and the saturating add.
module pairwise_energy_class_scorer_top #(
  parameter int NUM_CLASSES = pecs_pkg::NUM_CLASSES_DEF,
  parameter int NUM_VARS    = pecs_pkg::NUM_VARS_DEF,
  parameter int NUM_LEVELS  = pecs_pkg::NUM_LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: class_index[1:0], var_first[5:2], var_second[9:6],
  // level_first[11:10], level_second[13:12], weight_value[45:14], observed[48:46].
  input  logic [pecs_pkg::SDATA_W-1:0]    s_tdata,
  // Fields from bit 0: command[2:0].
  input  logic [pecs_pkg::CMD_W-1:0]      s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: score_class[1:0], score[49:2].
  output logic [pecs_pkg::MDATA_W-1:0]    m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [pecs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pecs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pecs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pecs_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  pecs_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_VARS    (NUM_VARS),
    .NUM_LEVELS  (NUM_LEVELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tvalid  (s_tvalid),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  assign s_tready = cmd.ready;

endmodule
